// ----- rtl/core/alle_pkg.sv -----
// Shared types and constants of the array linked list engine.
`timescale 1ns / 1ps
`default_nettype none

package alle_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam int VAL_W  = 32;
   localparam int OUT_W  = 4;

   localparam logic [LINK_W-1:0] END_MARK = LINK_W'(SLOTS);

   typedef enum logic [1:0] {
      ACT_FIND       = 2'd0,
      ACT_INS_BEFORE = 2'd1,
      ACT_INS_AFTER  = 2'd2,
      ACT_DELETE     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_CMP,
      S_FIRST,
      S_DEL,
      S_INS1,
      S_INS2,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              value_we;
      logic [SLOT_W-1:0] value_addr;
      logic [VAL_W-1:0]  value_data;
      logic              link_we;
      logic [SLOT_W-1:0] link_addr;
      logic [LINK_W-1:0] link_data;
      logic              used_set;
      logic              used_clr;
      logic              link_clr;
      logic [SLOT_W-1:0] used_addr;
   } store_cmd_type;

   typedef struct packed {
      logic [LINK_W-1:0] link_data;
      logic [VAL_W-1:0]  value_data;
      logic              used;
      logic              free_found;
      logic [SLOT_W-1:0] free_slot;
   } store_rsp_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] count;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/alle_store.sv -----
// Node store: value and link memories, occupied flags and the free slot finder.
`timescale 1ns / 1ps
`default_nettype none

module alle_store (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire alle_pkg::store_cmd_type cmd,
   output alle_pkg::store_rsp_type     rsp
);
   import alle_pkg::*;

   logic [VAL_W-1:0]  value_mem [SLOTS];
   logic [LINK_W-1:0] link_mem  [SLOTS];
   logic [SLOTS-1:0]  link_vld_ff;
   logic [SLOTS-1:0]  link_vld_in;
   logic [SLOTS-1:0]  used_ff;
   logic [SLOTS-1:0]  used_in;

   logic [VAL_W-1:0]  value_q_ff;
   logic [LINK_W-1:0] link_q_ff;
   logic              link_vld_q_ff;
   logic              used_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.value_we) begin
         value_mem[cmd.value_addr] <= cmd.value_data;
      end
      if (cmd.link_we) begin
         link_mem[cmd.link_addr] <= cmd.link_data;
      end
      if (cmd.rd_en) begin
         value_q_ff    <= value_mem[cmd.rd_addr];
         link_q_ff     <= link_mem[cmd.rd_addr];
         link_vld_q_ff <= link_vld_ff[cmd.rd_addr];
         used_q_ff     <= used_ff[cmd.rd_addr];
      end
   end

   // A link that was never written, or was dropped on delete, reads as the end mark.
   always_comb begin
      link_vld_in = link_vld_ff;
      used_in     = used_ff;
      if (cmd.link_we) begin
         link_vld_in[cmd.link_addr] = 1'b1;
      end
      if (cmd.link_clr) begin
         link_vld_in[cmd.used_addr] = 1'b0;
      end
      if (cmd.used_set) begin
         used_in[cmd.used_addr] = 1'b1;
      end
      if (cmd.used_clr) begin
         used_in[cmd.used_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
         used_ff     <= '0;
      end else begin
         link_vld_ff <= link_vld_in;
         used_ff     <= used_in;
      end
   end

   always_comb begin
      rsp.link_data  = link_vld_q_ff ? link_q_ff : END_MARK;
      rsp.value_data = value_q_ff;
      rsp.used       = used_q_ff;
      rsp.free_found = 1'b0;
      rsp.free_slot  = '0;
      // Walk downward so the lowest free slot wins; slot 0 is the sentinel.
      for (int i = SLOTS - 1; i >= 1; i--) begin
         if (!used_ff[i]) begin
            rsp.free_found = 1'b1;
            rsp.free_slot  = SLOT_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/alle_ctrl.sv -----
// Sequencer that walks the list and performs find, insert and delete.
`timescale 1ns / 1ps
`default_nettype none

module alle_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_action,
   input  wire logic [alle_pkg::VAL_W-1:0] req_key,
   input  wire logic [alle_pkg::VAL_W-1:0] req_new,
   output logic                         res_valid,
   input  wire logic                    res_ready,
   output alle_pkg::result_type         res,
   output alle_pkg::store_cmd_type      cmd,
   input  wire alle_pkg::store_rsp_type store_rsp
);
   import alle_pkg::*;

   state_type         state_ff, state_in;
   action_type        action_ff, action_in;
   logic [VAL_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  nv_ff, nv_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0] prev_ff, prev_in;
   logic [LINK_W-1:0] next_ff, next_in;
   logic [SLOT_W-1:0] steps_ff, steps_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   status_type        status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   action_type        req_act;
   logic              is_insert;
   logic              list_empty;
   logic              list_full;
   logic              match;
   logic              link_end;
   logic [SLOT_W-1:0] cur_slot;
   logic [SLOT_W-1:0] link_slot;

   assign req_act    = action_type'(req_action);
   assign is_insert  = (req_act == ACT_INS_BEFORE) || (req_act == ACT_INS_AFTER);
   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == SLOT_W'(SLOTS - 1));
   assign cur_slot   = cur_ff[SLOT_W-1:0];
   assign link_slot  = store_rsp.link_data[SLOT_W-1:0];
   assign link_end   = (store_rsp.link_data >= END_MARK);
   assign match      = store_rsp.used && (store_rsp.value_data == key_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!is_insert && list_empty) begin
                  state_in = S_DONE;
               end else if (is_insert && list_full) begin
                  state_in = S_DONE;
               end else if (is_insert && list_empty) begin
                  state_in = S_FIRST;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            state_in = link_end ? S_DONE : S_CMP;
         end
         S_CMP: begin
            priority if (match) begin
               unique case (action_ff)
                  ACT_FIND:   state_in = S_DONE;
                  ACT_DELETE: state_in = S_DEL;
                  default:    state_in = S_INS1;
               endcase
            end else if (link_end || steps_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_FIRST: state_in = S_DONE;
         S_DEL:   state_in = S_DONE;
         S_INS1:  state_in = store_rsp.free_found ? S_INS2 : S_DONE;
         S_INS2:  state_in = S_DONE;
         S_DONE:  state_in = res_ready ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      action_in = action_ff;
      key_in    = key_ff;
      nv_in     = nv_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      next_in   = next_ff;
      steps_in  = steps_ff;
      count_in  = count_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      cmd       = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = '0;
            if (req_valid) begin
               action_in = req_act;
               key_in    = req_key;
               nv_in     = req_new;
               status_in = ST_OK;
               slot_in   = '0;
               if (!is_insert && list_empty) begin
                  status_in = ST_EMPTY;
               end else if (is_insert && list_full) begin
                  status_in = ST_FULL;
               end
            end
         end
         S_HEAD: begin
            cur_in   = store_rsp.link_data;
            prev_in  = '0;
            steps_in = '0;
            if (link_end) begin
               status_in = ST_MISSING;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = link_slot;
            end
         end
         S_CMP: begin
            priority if (match) begin
               slot_in = cur_slot;
               if (action_ff == ACT_INS_BEFORE) begin
                  next_in = cur_ff;
               end else begin
                  next_in = store_rsp.link_data;
               end
               if (action_ff == ACT_INS_AFTER) begin
                  prev_in = cur_slot;
               end
            end else if (link_end || steps_ff == SLOT_W'(SLOTS - 1)) begin
               status_in = ST_MISSING;
            end else begin
               prev_in     = cur_slot;
               cur_in      = store_rsp.link_data;
               steps_in    = steps_ff + SLOT_W'(1);
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = link_slot;
            end
         end
         S_FIRST: begin
            cmd.value_we   = 1'b1;
            cmd.value_addr = SLOT_W'(1);
            cmd.value_data = nv_ff;
            cmd.link_we    = 1'b1;
            cmd.link_addr  = '0;
            cmd.link_data  = LINK_W'(1);
            cmd.used_set   = 1'b1;
            cmd.link_clr   = 1'b1;
            cmd.used_addr  = SLOT_W'(1);
            slot_in        = SLOT_W'(1);
            count_in       = SLOT_W'(1);
         end
         S_DEL: begin
            cmd.link_we   = 1'b1;
            cmd.link_addr = prev_ff;
            cmd.link_data = next_ff;
            cmd.used_clr  = 1'b1;
            cmd.link_clr  = 1'b1;
            cmd.used_addr = slot_ff;
            count_in      = count_ff - SLOT_W'(1);
         end
         S_INS1: begin
            if (store_rsp.free_found) begin
               cmd.value_we   = 1'b1;
               cmd.value_addr = store_rsp.free_slot;
               cmd.value_data = nv_ff;
               cmd.link_we    = 1'b1;
               cmd.link_addr  = store_rsp.free_slot;
               cmd.link_data  = next_ff;
               cmd.used_set   = 1'b1;
               cmd.used_addr  = store_rsp.free_slot;
               slot_in        = store_rsp.free_slot;
            end else begin
               status_in = ST_FULL;
               slot_in   = '0;
            end
         end
         S_INS2: begin
            cmd.link_we   = 1'b1;
            cmd.link_addr = prev_ff;
            cmd.link_data = {{(LINK_W - SLOT_W){1'b0}}, slot_ff};
            count_in      = count_ff + SLOT_W'(1);
         end
         S_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign res.status = status_ff;
   assign res.slot   = (status_ff == ST_OK) ? slot_ff : '0;
   assign res.count  = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      key_ff    <= key_in;
      nv_ff     <= nv_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      next_ff   <= next_in;
      steps_ff  <= steps_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/array_linked_list_engine_top.sv -----
// Top level of the array linked list engine: sequencer, node store and result register.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a singly linked list of 32-bit values in a 16-slot store whose slot 0 is a head
// sentinel, so at most 15 values are held. Each request transaction finds a value, inserts
// a new value before or after the first node holding a key, or deletes the first node
// holding a value; exactly one response transaction follows with a status, the slot and
// the stored count. One request is in work at a time. A request that ends early (a find
// or delete on an empty list, an insert into a full list) goes straight to its result, and
// an insert into an empty list writes the first node first. Any other request reads the
// head sentinel and then walks the list, one node per cycle through the single read port
// of the node memories; a delete then adds one write step and an insert two. A finished
// result waits in the output register while the next request is taken.
module array_linked_list_engine_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // action[1:0], key_value[33:2], new_value[65:34], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata   // status[1:0], slot[5:2], count[9:6], zero pad
);
   import alle_pkg::*;

   store_cmd_type cmd;
   store_rsp_type store_rsp;
   result_type    res;
   logic          res_valid;
   logic          res_ready;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;

   logic [OUT_W+SLOT_W-1:0] slot_ext;
   logic [OUT_W+SLOT_W-1:0] count_ext;

   alle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tdata[1:0]),
      .req_key    (req_tdata[33:2]),
      .req_new    (req_tdata[65:34]),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .cmd        (cmd),
      .store_rsp  (store_rsp)
   );

   alle_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (store_rsp)
   );

   // Slot and count leave as their low four bits.
   assign slot_ext  = {{OUT_W{1'b0}}, res.slot};
   assign count_ext = {{OUT_W{1'b0}}, res.count};

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, count_ext[OUT_W-1:0], slot_ext[OUT_W-1:0], res.status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
